FILE: rtl/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types and constants for the p-code stack machine.
// ----------------------------------------------------------------------------
package psm_pkg;
    localparam int STACK_DEPTH_DEF = 512;
    localparam int CODE_DEPTH_DEF  = 256;
    localparam int WORD_BITS_DEF   = 32;
    localparam int MAX_LEVEL_DEF   = 3;

    localparam logic [2:0] CMD_LIT = 3'd0;
    localparam logic [2:0] CMD_OPR = 3'd1;
    localparam logic [2:0] CMD_LOD = 3'd2;
    localparam logic [2:0] CMD_STO = 3'd3;
    localparam logic [2:0] CMD_CAL = 3'd4;
    localparam logic [2:0] CMD_INT = 3'd5;
    localparam logic [2:0] CMD_JMP = 3'd6;
    localparam logic [2:0] CMD_JPC = 3'd7;

    localparam logic [1:0] FLT_OK    = 2'd0;
    localparam logic [1:0] FLT_INVAL = 2'd1;
    localparam logic [1:0] FLT_RANGE = 2'd2;
    localparam logic [1:0] FLT_DIV0  = 2'd3;

    // Datapath operations.
    localparam logic [3:0] OP_RD_ADDR  = 4'd0;  // read stack at address register
    localparam logic [3:0] OP_LATCH_X  = 4'd1;  // x <= read data
    localparam logic [3:0] OP_LATCH_Y  = 4'd2;  // y <= read data
    localparam logic [3:0] OP_WR       = 4'd3;  // write wdata at address
    localparam logic [3:0] OP_DIV_GO   = 4'd4;
    localparam logic [3:0] OP_MUL_GO   = 4'd5;
    localparam logic [3:0] OP_NONE     = 4'd6;

    typedef struct packed {
        logic       rd;      // issue stack read at addr
        logic       wr;      // write wdata to addr
        logic       ld_x;    // capture read data into x
        logic       ld_y;    // capture read data into y
        logic       div_go;
        logic       mul_go;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic mul_busy;
    } t_dp_sts;
endpackage

FILE: rtl/psm_datapath.sv
// ----------------------------------------------------------------------------
// psm_datapath
// Data stack memory, operand registers and a multicycle multiply/divide unit.
// ----------------------------------------------------------------------------
module psm_datapath
    import psm_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF,
    localparam int SAW        = $clog2(STACK_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [SAW-1:0]       i_addr,
    input  logic [WORD_BITS-1:0] i_wdata,
    output logic [WORD_BITS-1:0] o_rdata,
    output logic [WORD_BITS-1:0] o_x,
    output logic [WORD_BITS-1:0] o_y,
    output logic [WORD_BITS-1:0] o_prod,
    output logic [WORD_BITS-1:0] o_quot,
    output t_dp_sts              o_sts
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] r_mem [STACK_DEPTH];
    logic [WORD_BITS-1:0] r_rdata, r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_addr];
        end
        if (i_cmd.ld_x) begin
            r_x <= r_rdata;
        end
        if (i_cmd.ld_y) begin
            r_y <= r_rdata;
        end
    end

    // Shift-add multiplier, one bit a cycle.
    logic [WORD_BITS-1:0] r_mac, r_mplr, r_mcand, n_mac;
    logic [CW-1:0]        r_mcnt;
    logic                 r_mbusy;
    always_comb begin
        n_mac = r_mac;
        if (r_mplr[0]) begin
            n_mac = r_mac + r_mcand;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mcnt  <= '0;
        end else if (i_cmd.mul_go) begin
            r_mbusy <= 1'b1;
            r_mcnt  <= CW'(WORD_BITS);
        end else if (r_mbusy) begin
            r_mcnt <= r_mcnt - 1'b1;
            if (r_mcnt == CW'(1)) begin
                r_mbusy <= 1'b0;
            end
        end
        if (i_cmd.mul_go) begin
            r_mac   <= '0;
            r_mplr  <= r_y;
            r_mcand <= r_x;
        end else if (r_mbusy) begin
            r_mac   <= n_mac;
            r_mplr  <= r_mplr >> 1;
            r_mcand <= r_mcand << 1;
        end
    end

    // Restoring divider on magnitudes, one quotient bit a cycle.
    logic [WORD_BITS-1:0] r_dq, r_dd, r_rem;
    logic [WORD_BITS:0]   n_rem_sh, n_diff;
    logic [CW-1:0]        r_dcnt;
    logic                 r_dbusy, r_dneg;
    logic [WORD_BITS-1:0] ma, mb;
    assign ma = r_x[WORD_BITS-1] ? -r_x : r_x;
    assign mb = r_y[WORD_BITS-1] ? -r_y : r_y;
    assign n_rem_sh = {r_rem, r_dq[WORD_BITS-1]};
    assign n_diff   = n_rem_sh - {1'b0, r_dd};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_go) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= CW'(WORD_BITS);
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt - 1'b1;
            if (r_dcnt == CW'(1)) begin
                r_dbusy <= 1'b0;
            end
        end
        if (i_cmd.div_go) begin
            r_dq   <= ma;
            r_dd   <= mb;
            r_rem  <= '0;
            r_dneg <= r_x[WORD_BITS-1] ^ r_y[WORD_BITS-1];
        end else if (r_dbusy) begin
            if (!n_diff[WORD_BITS]) begin
                r_rem <= n_diff[WORD_BITS-1:0];
                r_dq  <= {r_dq[WORD_BITS-2:0], 1'b1};
            end else begin
                r_rem <= n_rem_sh[WORD_BITS-1:0];
                r_dq  <= {r_dq[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_prod  = r_mac;
    assign o_quot  = r_dneg ? -r_dq : r_dq;
    assign o_sts   = '{div_busy: r_dbusy, mul_busy: r_mbusy};
endmodule

FILE: rtl/psm_control.sv
// ----------------------------------------------------------------------------
// psm_control
// Instruction sequencer: holds pc, top and base, walks static links and
// issues stack reads, writes and arithmetic to the datapath.
// ----------------------------------------------------------------------------
module psm_control
    import psm_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int CODE_DEPTH  = CODE_DEPTH_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF,
    parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
    localparam int SAW        = $clog2(STACK_DEPTH),
    localparam int PCW        = $clog2(CODE_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_cmd,
    input  logic [1:0]           i_level,
    input  logic signed [11:0]   i_operand,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PCW-1:0]       o_pc,
    output logic [SAW-1:0]       o_top,
    output logic [SAW-1:0]       o_base,
    output logic [WORD_BITS-1:0] o_top_value,
    output logic [1:0]           o_fault,
    output t_dp_cmd              o_dp,
    output logic [SAW-1:0]       o_addr,
    output logic [WORD_BITS-1:0] o_wdata,
    input  logic [WORD_BITS-1:0] i_rdata,
    input  logic [WORD_BITS-1:0] i_x,
    input  logic [WORD_BITS-1:0] i_y,
    input  logic [WORD_BITS-1:0] i_prod,
    input  logic [WORD_BITS-1:0] i_quot,
    input  t_dp_sts              i_sts
);
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DEC   = 5'd2;
    localparam logic [4:0] S_WALK  = 5'd3;   // read link at r_at
    localparam logic [4:0] S_WALKW = 5'd4;   // link data ready
    localparam logic [4:0] S_EXEC  = 5'd5;
    localparam logic [4:0] S_RDY   = 5'd6;   // read top (y)
    localparam logic [4:0] S_RDYW  = 5'd7;
    localparam logic [4:0] S_RDX   = 5'd8;
    localparam logic [4:0] S_RDXW  = 5'd9;
    localparam logic [4:0] S_ALU   = 5'd10;
    localparam logic [4:0] S_MDW   = 5'd11;
    localparam logic [4:0] S_LODW  = 5'd12;
    localparam logic [4:0] S_RET1  = 5'd13;
    localparam logic [4:0] S_RET2  = 5'd14;
    localparam logic [4:0] S_RET3  = 5'd15;
    localparam logic [4:0] S_CAL1  = 5'd16;
    localparam logic [4:0] S_CAL2  = 5'd17;
    localparam logic [4:0] S_FIN   = 5'd18;  // on fault, keep top and base, step pc
    localparam logic [4:0] S_FINW  = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;
    localparam logic [4:0] S_STOW  = 5'd21;

    localparam int EW = SAW + 14;  // wide signed index arithmetic

    logic [4:0]           r_state;
    logic [PCW-1:0]       r_pc, r_npc;
    logic [SAW-1:0]       r_top, r_base, r_nt, r_nb, r_at, r_addr;
    logic [SAW:0]         r_clr;
    logic [2:0]           r_cmd;
    logic [1:0]           r_lev;
    logic signed [11:0]   r_opd;
    logic [1:0]           r_fault;
    logic [WORD_BITS-1:0] r_wdata, r_res, r_tv;
    logic                 r_wr, r_rd, r_ldx, r_ldy, r_dgo, r_mgo, r_ovalid;
    logic [3:0]           r_step;

    logic signed [EW-1:0] e_top, e_base, e_at, e_opd;
    assign e_top  = EW'(signed'({1'b0, r_top}));
    assign e_base = EW'(signed'({1'b0, r_base}));
    assign e_at   = EW'(signed'({1'b0, r_at}));
    assign e_opd  = EW'(r_opd);

    function automatic logic in_rng(input logic signed [EW-1:0] v);
        return v >= 0 && v < EW'(STACK_DEPTH);
    endfunction

    function automatic logic [PCW-1:0] pc_of(input logic signed [12:0] v);
        logic signed [31:0] r;
        r = 32'(v) % CODE_DEPTH;
        if (r < 0) begin
            r = r + CODE_DEPTH;
        end
        return PCW'(r);
    endfunction

    logic                 is_arith, lt_xy, lt_yx;
    logic signed [11:0]   o12;
    assign o12      = r_opd;
    assign is_arith = (o12 >= 2 && o12 <= 5) || (o12 >= 8 && o12 <= 13);
    assign lt_xy = $signed(i_x) < $signed(i_y);
    assign lt_yx = $signed(i_y) < $signed(i_x);
    logic rd_big;
    assign rd_big = (WORD_BITS > SAW) ? (i_rdata >= WORD_BITS'(STACK_DEPTH)) : 1'b0;

    always_ff @(posedge i_clk) begin
        r_wr  <= 1'b0;
        r_rd  <= 1'b0;
        r_ldx <= 1'b0;
        r_ldy <= 1'b0;
        r_dgo <= 1'b0;
        r_mgo <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pc     <= '0;
            r_top    <= '0;
            r_base   <= SAW'(1);
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_wr    <= 1'b1;
                    r_addr  <= r_clr[SAW-1:0];
                    r_wdata <= '0;
                    r_clr   <= r_clr + 1'b1;
                    if (r_clr == (SAW+1)'(STACK_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_lev   <= i_level;
                        r_opd   <= i_operand;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_npc   <= PCW'(r_pc + 1'b1);
                    r_nt    <= r_top;
                    r_nb    <= r_base;
                    r_fault <= FLT_OK;
                    r_at    <= r_base;
                    r_step  <= {2'b0, r_lev};
                    if (32'(r_lev) > MAX_LEVEL &&
                        (r_cmd == CMD_LOD || r_cmd == CMD_STO || r_cmd == CMD_CAL)) begin
                        r_fault <= FLT_INVAL;
                        r_state <= S_FIN;
                    end else if ((r_cmd == CMD_LOD || r_cmd == CMD_STO || r_cmd == CMD_CAL)
                                 && r_lev != 2'd0) begin
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_WALK: begin
                    r_addr  <= r_at;
                    r_rd    <= 1'b1;
                    r_state <= S_WALKW;
                    r_step  <= r_step - 1'b1;
                end
                S_WALKW: begin
                    if (r_rd) begin
                        r_state <= S_WALKW;
                    end else if (rd_big) begin
                        r_fault <= FLT_RANGE;
                        r_state <= S_FIN;
                    end else begin
                        r_at    <= SAW'(i_rdata);
                        r_state <= (r_step == 4'd0) ? S_EXEC : S_WALK;
                    end
                end
                S_EXEC: begin
                    r_state <= S_FIN;
                    unique case (r_cmd)
                        CMD_LIT: begin
                            if (!in_rng(e_top + EW'(1))) begin
                                r_fault <= FLT_RANGE;
                            end else begin
                                r_nt    <= SAW'(e_top + 1);
                                r_addr  <= SAW'(e_top + 1);
                                r_wdata <= WORD_BITS'(signed'(r_opd));
                                r_wr    <= 1'b1;
                            end
                        end
                        CMD_OPR: begin
                            if (o12 == 12'sd0) begin
                                if (!in_rng(e_base - EW'(1)) || !in_rng(e_base + EW'(2))) begin
                                    r_fault <= FLT_RANGE;
                                end else begin
                                    r_addr  <= SAW'(e_base + 1);
                                    r_rd    <= 1'b1;
                                    r_state <= S_RET1;
                                end
                            end else if (o12 == 12'sd1 || o12 == 12'sd6 || is_arith) begin
                                if (is_arith && r_top == '0) begin
                                    r_fault <= FLT_RANGE;
                                end else begin
                                    r_state <= S_RDY;
                                end
                            end else begin
                                r_fault <= FLT_INVAL;
                            end
                        end
                        CMD_LOD: begin
                            if (!in_rng(e_top + EW'(1)) || !in_rng(e_at + e_opd)) begin
                                r_fault <= FLT_RANGE;
                            end else begin
                                r_addr  <= SAW'(e_at + e_opd);
                                r_rd    <= 1'b1;
                                r_state <= S_LODW;
                                r_step  <= 4'd0;
                            end
                        end
                        CMD_STO: begin
                            if (r_top == '0 || !in_rng(e_at + e_opd)) begin
                                r_fault <= FLT_RANGE;
                            end else begin
                                r_addr  <= r_top;
                                r_rd    <= 1'b1;
                                r_state <= S_STOW;
                                r_step  <= 4'd0;
                            end
                        end
                        CMD_CAL: begin
                            if (!in_rng(e_top + EW'(3))) begin
                                r_fault <= FLT_RANGE;
                            end else begin
                                r_addr  <= SAW'(e_top + 1);
                                r_wdata <= WORD_BITS'(r_at);
                                r_wr    <= 1'b1;
                                r_state <= S_CAL1;
                            end
                        end
                        CMD_INT: begin
                            if (!in_rng(e_top + e_opd)) begin
                                r_fault <= FLT_RANGE;
                            end else begin
                                r_nt <= SAW'(e_top + e_opd);
                            end
                        end
                        CMD_JMP: begin
                            r_npc <= pc_of(13'(r_opd) - 13'sd1);
                        end
                        CMD_JPC: begin
                            if (r_top == '0) begin
                                r_fault <= FLT_RANGE;
                            end else begin
                                r_state <= S_RDY;
                            end
                        end
                        default: r_fault <= FLT_INVAL;
                    endcase
                end
                S_RET1: begin
                    r_addr  <= SAW'(e_base + 2);
                    r_rd    <= 1'b1;
                    r_ldx   <= 1'b0;
                    r_state <= S_RET2;
                end
                S_RET2: begin
                    // Read data now holds the saved base.
                    r_res   <= i_rdata;
                    r_state <= S_RET3;
                end
                S_RET3: begin
                    if (WORD_BITS > SAW && r_res >= WORD_BITS'(STACK_DEPTH)) begin
                        r_fault <= FLT_RANGE;
                    end else begin
                        r_nt  <= SAW'(e_base - 1);
                        r_nb  <= SAW'(r_res);
                        r_npc <= PCW'(i_rdata);
                    end
                    r_state <= S_FIN;
                end
                S_CAL1: begin
                    r_addr  <= SAW'(e_top + 2);
                    r_wdata <= WORD_BITS'(r_base);
                    r_wr    <= 1'b1;
                    r_state <= S_CAL2;
                end
                S_CAL2: begin
                    r_addr  <= SAW'(e_top + 3);
                    r_wdata <= WORD_BITS'(r_npc);
                    r_wr    <= 1'b1;
                    r_nb    <= SAW'(e_top + 1);
                    r_npc   <= pc_of(13'(r_opd));
                    r_state <= S_FIN;
                end
                S_LODW: begin
                    // Wait for the read to land.
                    if (r_step == 4'd0) begin
                        r_step <= 4'd1;
                    end else begin
                        r_nt    <= SAW'(e_top + 1);
                        r_addr  <= SAW'(e_top + 1);
                        r_wdata <= i_rdata;
                        r_wr    <= 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_STOW: begin
                    if (r_step == 4'd0) begin
                        r_step <= 4'd1;
                    end else begin
                        r_addr  <= SAW'(e_at + e_opd);
                        r_wdata <= i_rdata;
                        r_wr    <= 1'b1;
                        r_nt    <= r_top - 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_RDY: begin
                    r_addr  <= r_top;
                    r_rd    <= 1'b1;
                    r_state <= S_RDYW;
                end
                S_RDYW: begin
                    if (!r_rd) begin
                        r_ldy   <= 1'b1;
                        r_state <= (r_cmd == CMD_OPR && is_arith) ? S_RDX : S_ALU;
                    end
                end
                S_RDX: begin
                    if (!r_ldy) begin
                        r_addr  <= r_top - 1'b1;
                        r_rd    <= 1'b1;
                        r_state <= S_RDXW;
                    end
                end
                S_RDXW: begin
                    if (!r_rd) begin
                        r_ldx   <= 1'b1;
                        r_state <= S_ALU;
                    end
                end
                S_ALU: begin
                    if (!r_ldx && !r_ldy) begin
                        r_state <= S_FIN;
                        r_addr  <= r_top - 1'b1;
                        r_nt    <= r_top - 1'b1;
                        r_wr    <= 1'b1;
                        if (r_cmd == CMD_JPC) begin
                            r_wr <= 1'b0;
                            if (i_y == '0) begin
                                r_npc <= pc_of(13'(r_opd) - 13'sd1);
                            end
                        end else if (o12 == 12'sd1 || o12 == 12'sd6) begin
                            r_addr  <= r_top;
                            r_nt    <= r_top;
                            r_wdata <= (o12 == 12'sd1) ? -i_y : WORD_BITS'(i_y[0]);
                        end else begin
                            unique case (o12)
                                12'sd2: r_wdata <= i_x + i_y;
                                12'sd3: r_wdata <= i_x - i_y;
                                12'sd4: begin
                                    r_wr    <= 1'b0;
                                    r_mgo   <= 1'b1;
                                    r_state <= S_MDW;
                                end
                                12'sd5: begin
                                    r_wr <= 1'b0;
                                    if (i_y == '0) begin
                                        r_fault <= FLT_DIV0;
                                        r_nt    <= r_top;
                                    end else begin
                                        r_dgo   <= 1'b1;
                                        r_state <= S_MDW;
                                    end
                                end
                                12'sd8:  r_wdata <= WORD_BITS'(i_x == i_y);
                                12'sd9:  r_wdata <= WORD_BITS'(i_x != i_y);
                                12'sd10: r_wdata <= WORD_BITS'(lt_xy);
                                12'sd11: r_wdata <= WORD_BITS'(!lt_xy);
                                12'sd12: r_wdata <= WORD_BITS'(lt_yx);
                                default: r_wdata <= WORD_BITS'(!lt_yx);
                            endcase
                        end
                    end
                end
                S_MDW: begin
                    if (!r_mgo && !r_dgo && !i_sts.mul_busy && !i_sts.div_busy) begin
                        r_wdata <= (o12 == 12'sd4) ? i_prod : i_quot;
                        r_wr    <= 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_fault != FLT_OK) begin
                        r_nt  <= r_top;
                        r_nb  <= r_base;
                        r_npc <= PCW'(r_pc + 1'b1);
                    end
                    r_state <= S_FINW;
                end
                S_FINW: begin
                    r_pc     <= r_npc;
                    r_top    <= r_nt;
                    r_base   <= r_nb;
                    r_addr   <= r_nt;
                    r_rd     <= 1'b1;
                    r_state  <= S_OUT;
                    r_step   <= 4'd0;
                end
                S_OUT: begin
                    if (r_step == 4'd0) begin
                        r_step <= 4'd1;
                    end else if (!r_ovalid) begin
                        r_tv     <= i_rdata;
                        r_ovalid <= 1'b1;
                    end else if (i_ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_pc        = r_pc;
    assign o_top       = r_top;
    assign o_base      = r_base;
    assign o_top_value = r_tv;
    assign o_fault     = r_fault;
    assign o_addr      = r_addr;
    assign o_wdata     = r_wdata;
    assign o_dp        = '{rd: r_rd, wr: r_wr, ld_x: r_ldx, ld_y: r_ldy,
                           div_go: r_dgo, mul_go: r_mgo};

    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rd && r_wr)) else $error("read and write issued together");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_tv))
        else $error("result dropped before taken");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !o_ready) else $error("item taken while result pending");
endmodule

FILE: rtl/pcode_stack_machine_execute.sv
// Each item runs through decode, a static-link walk for LOD, STO and CAL at a
//   nonzero level, execute and finish; MUL and DIV wait on the shift-add and
//   restoring units.
// Throughput: one item at a time; the next item is accepted in the cycle after
//   the result is taken, at the earliest.
// Reset: pc 0, top 0, base 1; then a clearing pass zeroes every stack word
//   before the first item is accepted.
// ----------------------------------------------------------------------------
// pcode_stack_machine_execute
// PL/0 p-code machine executing one instruction per input item.
// ----------------------------------------------------------------------------
module pcode_stack_machine_execute
    import psm_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int CODE_DEPTH  = CODE_DEPTH_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF,
    parameter int MAX_LEVEL   = MAX_LEVEL_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_cmd,
    input  logic [1:0]                      i_level,
    input  logic signed [11:0]              i_operand,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [$clog2(CODE_DEPTH)-1:0]   o_next_pc,
    output logic [$clog2(STACK_DEPTH)-1:0]  o_stack_top,
    output logic signed [WORD_BITS-1:0]     o_top_value,
    output logic [$clog2(STACK_DEPTH)-1:0]  o_frame_base,
    output logic                            o_halted,
    output logic [1:0]                      o_fault
);
    localparam int SAW = $clog2(STACK_DEPTH);

    t_dp_cmd              dp_cmd;
    t_dp_sts              dp_sts;
    logic [SAW-1:0]       addr;
    logic [WORD_BITS-1:0] wdata, rdata, x, y, prod, quot, tv;

    psm_control #(
        .STACK_DEPTH(STACK_DEPTH), .CODE_DEPTH(CODE_DEPTH),
        .WORD_BITS(WORD_BITS), .MAX_LEVEL(MAX_LEVEL)
    ) u_ctl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd, .i_level, .i_operand,
        .o_valid, .i_ready, .o_pc(o_next_pc), .o_top(o_stack_top),
        .o_base(o_frame_base), .o_top_value(tv), .o_fault, .o_dp(dp_cmd),
        .o_addr(addr), .o_wdata(wdata), .i_rdata(rdata), .i_x(x), .i_y(y),
        .i_prod(prod), .i_quot(quot), .i_sts(dp_sts)
    );

    psm_datapath #(.STACK_DEPTH(STACK_DEPTH), .WORD_BITS(WORD_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(dp_cmd), .i_addr(addr), .i_wdata(wdata),
        .o_rdata(rdata), .o_x(x), .o_y(y), .o_prod(prod), .o_quot(quot),
        .o_sts(dp_sts)
    );

    assign o_top_value = tv;
    assign o_halted    = (o_next_pc == '0);
endmodule
